// File: rtl/csg_pkg.sv
// Package for the complex squash gradient block: widths, cell payload types
// and small helpers shared by the interfaces, the cells and the top level.
`timescale 1ns / 1ps
package csg_pkg;

	localparam int DW        = 24;        // data field width
	localparam int FB        = 16;        // fraction bits
	localparam int SQW       = 2 * DW;    // squared magnitude width
	localparam int PW        = DW + 1;    // r + 1 width
	localparam int RPW       = DW + PW;   // r * (r + 1) width
	localparam int DENW      = 74;        // r * (r + 1)^2 width
	localparam int NMW       = 72;        // numerator magnitude width
	localparam int RW        = 100;       // divider remainder width
	localparam int SQ_STAGES = DW;        // one result bit per square root cell
	localparam int DV_STAGES = DW;        // one quotient bit per divider cell

	localparam logic [DW-1:0] POS_LIMIT = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] NEG_LIMIT = {1'b1, {(DW-1){1'b0}}};

	typedef struct packed {
		logic [SQW-1:0] v;
		logic [SQW-1:0] res;
		logic [SQW-1:0] bw;
	} sq_data_t;

	typedef struct packed {
		logic [DW-1:0]  gxm;
		logic [DW-1:0]  gym;
		logic [DW-1:0]  xm;
		logic [DW-1:0]  ym;
		logic           gxn;
		logic           gyn;
		logic           xn;
		logic           yn;
		logic [SQW-1:0] cmag;
		logic           cneg;
		logic           zero;
		logic           last;
	} sq_side_t;

	typedef struct packed {
		sq_data_t d;
		sq_side_t s;
	} sq_cell_t;

	typedef struct packed {
		logic [RW-1:0] rem_re;
		logic [RW-1:0] rem_im;
		logic [RW-1:0] dsh;
		logic [DW-1:0] q_re;
		logic [DW-1:0] q_im;
	} dv_data_t;

	typedef struct packed {
		logic neg_re;
		logic neg_im;
		logic ovf_re;
		logic ovf_im;
		logic zero;
		logic last;
	} dv_side_t;

	typedef struct packed {
		dv_data_t d;
		dv_side_t s;
	} dv_cell_t;

	// Magnitude of a two's complement field; the most negative value maps to 2^(DW-1).
	function automatic logic [DW-1:0] mag(input logic [DW-1:0] v);
		return v[DW-1] ? DW'(-v) : v;
	endfunction

endpackage

// File: rtl/csg_in_if.sv
// Input channel of the complex squash gradient block: valid/ready plus one
// complex value and its upstream gradient. Depends on csg_pkg.
`timescale 1ns / 1ps
interface csg_in_if import csg_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic signed [DW-1:0] grad_re;
	logic signed [DW-1:0] grad_im;
	logic signed [DW-1:0] val_re;
	logic signed [DW-1:0] val_im;
	logic                 last_in;

	modport source(output valid, grad_re, grad_im, val_re, val_im, last_in, input ready);
	modport sink(input valid, grad_re, grad_im, val_re, val_im, last_in, output ready);
endinterface

// File: rtl/csg_out_if.sv
// Output channel of the complex squash gradient block: valid/ready plus the
// gradient result and its flags. Depends on csg_pkg.
`timescale 1ns / 1ps
interface csg_out_if import csg_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic signed [DW-1:0] out_re;
	logic signed [DW-1:0] out_im;
	logic                 zero_magnitude;
	logic                 saturated;
	logic                 last_out;

	modport source(output valid, out_re, out_im, zero_magnitude, saturated, last_out,
		input ready);
	modport sink(input valid, out_re, out_im, zero_magnitude, saturated, last_out,
		output ready);
endinterface

// File: rtl/complex_squash_gradient_unit.sv
// Complex squash activation gradient, one complex element per transaction.
// Depends on csg_pkg, csg_in_if, csg_out_if, csg_sqrt_cell and csg_div_cell.
//
// Usage: din carries an upstream gradient (grad_re, grad_im), the forward
// value (val_re, val_im) and a last marker, all Q7.16 in 24 bits. dout gives
// the gradient (out_re, out_im), saturated to range, with zero_magnitude,
// saturated and last_out. A transaction moves when valid and ready are high.
// From input to output register an element passes two input stages, a
// chain of 24 square root cells (one root bit each), five multiply and add
// stages, a chain of 24 divider cells (one quotient bit per lane each) and
// the output register. Every stage holds one element, so the block accepts
// one element per cycle unless a stalled dout has filled every stage; it is
// set by that single-element-per-stage chain. When dout stalls, elements pile
// up stage by stage; empty stages still fill, and din.ready falls only once every stage holds an element.
// Reset clears all valid bits, so din.ready is high as soon as reset ends.
// A zero forward value gives zero outputs with zero_magnitude set.
`timescale 1ns / 1ps
module complex_squash_gradient_unit import csg_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	csg_in_if.sink    din,
	csg_out_if.source dout
);
	typedef struct packed {
		logic [NMW-1:0] nm;
		logic           neg;
	} nm_t;

	function automatic nm_t nm_sel(input logic [NMW-1:0] t1, input logic [NMW-1:0] t2,
		input logic n1, input logic n2);
		nm_t r;
		if (n1 == n2) begin
			r.nm  = t1 + t2;
			r.neg = n1;
		end else if (t1 >= t2) begin
			r.nm  = t1 - t2;
			r.neg = n1;
		end else begin
			r.nm  = t2 - t1;
			r.neg = n2;
		end
		return r;
	endfunction

	// ---------------- stage 1: squares and cross products ----------------
	logic                  v_s1, r_s1;
	logic signed [DW-1:0]  gx_s1, gy_s1, x_s1, y_s1;
	logic [SQW-1:0]        xsq_s1, ysq_s1;
	logic signed [SQW-1:0] a_s1, b_s1;
	logic                  zero_s1, last_s1;
	logic signed [SQW-1:0] xsq_c, ysq_c, a_c, b_c;

	assign xsq_c = din.val_re * din.val_re;
	assign ysq_c = din.val_im * din.val_im;
	assign a_c   = din.val_im * din.grad_re;
	assign b_c   = din.val_re * din.grad_im;

	// ---------------- stage 2: magnitude sum and cross term ----------------
	logic                v_s2, r_s2;
	sq_cell_t            sq_start_s2;
	logic signed [SQW:0] cdiff;
	sq_cell_t            sq_start_c;

	always_comb begin
		cdiff                  = {a_s1[SQW-1], a_s1} - {b_s1[SQW-1], b_s1};
		sq_start_c.d.v         = xsq_s1 + ysq_s1;
		sq_start_c.d.res       = '0;
		sq_start_c.d.bw        = SQW'(1) << (SQW - 2);
		sq_start_c.s.gxm       = mag(gx_s1);
		sq_start_c.s.gym       = mag(gy_s1);
		sq_start_c.s.xm        = mag(x_s1);
		sq_start_c.s.ym        = mag(y_s1);
		sq_start_c.s.gxn       = gx_s1[DW-1];
		sq_start_c.s.gyn       = gy_s1[DW-1];
		sq_start_c.s.xn        = x_s1[DW-1];
		sq_start_c.s.yn        = y_s1[DW-1];
		sq_start_c.s.cneg      = cdiff[SQW];
		sq_start_c.s.cmag      = cdiff[SQW] ? SQW'(-cdiff) : cdiff[SQW-1:0];
		sq_start_c.s.zero      = zero_s1;
		sq_start_c.s.last      = last_s1;
	end

	// ---------------- square root chain ----------------
	sq_cell_t sq_d [0:SQ_STAGES];
	logic     sq_v [0:SQ_STAGES];
	logic     sq_r [0:SQ_STAGES];

	assign sq_d[0] = sq_start_s2;
	assign sq_v[0] = v_s2;

	for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sq
		csg_sqrt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (sq_v[k]),
			.in_ready (sq_r[k]),
			.in_data  (sq_d[k]),
			.out_valid(sq_v[k+1]),
			.out_ready(sq_r[k+1]),
			.out_data (sq_d[k+1])
		);
	end

	// ---------------- stage 3: r * (r + 1) and numerator products ----------------
	logic           v_s3, r_s3;
	logic [PW-1:0]  p_s3;
	logic [RPW-1:0] rp_s3;
	logic [SQW-1:0] t1re_s3, t1im_s3, t2rl_s3, t2rh_s3, t2il_s3, t2ih_s3;
	logic           n1re_s3, n2re_s3, n1im_s3, n2im_s3, zero_s3, last_s3;
	logic [DW-1:0]  r3;
	logic [PW-1:0]  p3;
	logic [RPW-1:0] rp3;
	logic [SQW-1:0] t1re3, t1im3, t2rl3, t2rh3, t2il3, t2ih3;
	sq_side_t       sd3;

	always_comb begin
		sd3   = sq_d[SQ_STAGES].s;
		r3    = sq_d[SQ_STAGES].d.res[DW-1:0];
		p3    = {1'b0, r3} + (PW'(1) << FB);
		rp3   = r3 * p3;
		t1re3 = sd3.gxm * r3;
		t1im3 = sd3.gym * r3;
		t2rl3 = sd3.ym * sd3.cmag[DW-1:0];
		t2rh3 = sd3.ym * sd3.cmag[SQW-1:DW];
		t2il3 = sd3.xm * sd3.cmag[DW-1:0];
		t2ih3 = sd3.xm * sd3.cmag[SQW-1:DW];
	end

	// ---------------- stage 4: denominator partials, cross term sums ----------------
	logic             v_s4, r_s4;
	logic [RPW:0]     denlo_s4;
	logic [RPW-1:0]   denhi_s4;
	logic [NMW-1:0]   t2re_s4, t2im_s4;
	logic [SQW-1:0]   t1re_s4, t1im_s4;
	logic             n1re_s4, n2re_s4, n1im_s4, n2im_s4, zero_s4, last_s4;
	logic [RPW:0]     denlo4;
	logic [RPW-1:0]   denhi4;

	assign denlo4 = rp_s3[PW-1:0] * p_s3;
	assign denhi4 = rp_s3[RPW-1:PW] * p_s3;

	// ---------------- stage 5: denominator and signed numerators ----------------
	logic            v_s5, r_s5;
	logic [DENW-1:0] den_s5;
	nm_t             nre_s5, nim_s5;
	logic            zero_s5, last_s5;
	logic [NMW-1:0]  t1re5, t1im5;

	assign t1re5 = NMW'({t1re_s4, {FB{1'b0}}});
	assign t1im5 = NMW'({t1im_s4, {FB{1'b0}}});

	// ---------------- stage 6: dividend and divisor for rounding ----------------
	logic          v_s6, r_s6;
	logic [RW-1:0] nre_s6, nim_s6, dd_s6;
	logic          neg_re_s6, neg_im_s6, zero_s6, last_s6;

	// ---------------- stage 7: overflow check, divider setup ----------------
	logic     v_s7, r_s7;
	dv_cell_t dv_start_s7;
	logic [RW-1:0] dtop;

	assign dtop = dd_s6 << DW;

	// ---------------- divider chain ----------------
	dv_cell_t dv_d [0:DV_STAGES];
	logic     dv_v [0:DV_STAGES];
	logic     dv_r [0:DV_STAGES];

	assign dv_d[0] = dv_start_s7;
	assign dv_v[0] = v_s7;

	for (genvar k = 0; k < DV_STAGES; k++) begin : g_dv
		csg_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (dv_v[k]),
			.in_ready (dv_r[k]),
			.in_data  (dv_d[k]),
			.out_valid(dv_v[k+1]),
			.out_ready(dv_r[k+1]),
			.out_data (dv_d[k+1])
		);
	end

	// ---------------- output register: saturation and sign ----------------
	logic          v_o_q, r_o;
	logic [DW-1:0] re_o_q, im_o_q;
	logic          zero_o_q, sat_o_q, last_o_q;
	logic [DW-1:0] lim_re, lim_im, val_re, val_im;
	logic          sat_re, sat_im;
	dv_cell_t      dvo;

	always_comb begin
		dvo    = dv_d[DV_STAGES];
		lim_re = dvo.s.neg_re ? NEG_LIMIT : POS_LIMIT;
		lim_im = dvo.s.neg_im ? NEG_LIMIT : POS_LIMIT;
		sat_re = dvo.s.ovf_re || (dvo.d.q_re > lim_re);
		sat_im = dvo.s.ovf_im || (dvo.d.q_im > lim_im);
		val_re = sat_re ? lim_re : dvo.d.q_re;
		val_im = sat_im ? lim_im : dvo.d.q_im;
	end

	// ---------------- ready chain ----------------
	assign r_o             = !v_o_q || dout.ready;
	assign dv_r[DV_STAGES] = r_o;
	assign r_s7            = !v_s7 || dv_r[0];
	assign r_s6            = !v_s6 || r_s7;
	assign r_s5            = !v_s5 || r_s6;
	assign r_s4            = !v_s4 || r_s5;
	assign r_s3            = !v_s3 || r_s4;
	assign sq_r[SQ_STAGES] = r_s3;
	assign r_s2            = !v_s2 || sq_r[0];
	assign r_s1            = !v_s1 || r_s2;
	assign din.ready       = r_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_o_q <= 1'b0;
		end else begin
			if (r_s1) v_s1 <= din.valid;
			if (r_s2) v_s2 <= v_s1;
			if (r_s3) v_s3 <= sq_v[SQ_STAGES];
			if (r_s4) v_s4 <= v_s3;
			if (r_s5) v_s5 <= v_s4;
			if (r_s6) v_s6 <= v_s5;
			if (r_s7) v_s7 <= v_s6;
			if (r_o)  v_o_q <= dv_v[DV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (r_s1 && din.valid) begin
			gx_s1   <= din.grad_re;
			gy_s1   <= din.grad_im;
			x_s1    <= din.val_re;
			y_s1    <= din.val_im;
			xsq_s1  <= xsq_c;
			ysq_s1  <= ysq_c;
			a_s1    <= a_c;
			b_s1    <= b_c;
			zero_s1 <= (din.val_re == '0) && (din.val_im == '0);
			last_s1 <= din.last_in;
		end
		if (r_s2 && v_s1) begin
			sq_start_s2 <= sq_start_c;
		end
		if (r_s3 && sq_v[SQ_STAGES]) begin
			p_s3    <= p3;
			rp_s3   <= rp3;
			t1re_s3 <= t1re3;
			t1im_s3 <= t1im3;
			t2rl_s3 <= t2rl3;
			t2rh_s3 <= t2rh3;
			t2il_s3 <= t2il3;
			t2ih_s3 <= t2ih3;
			n1re_s3 <= sd3.gxn;
			n2re_s3 <= sd3.yn ^ sd3.cneg;
			n1im_s3 <= sd3.gyn;
			n2im_s3 <= ~(sd3.xn ^ sd3.cneg);
			zero_s3 <= sd3.zero;
			last_s3 <= sd3.last;
		end
		if (r_s4 && v_s3) begin
			denlo_s4 <= denlo4;
			denhi_s4 <= denhi4;
			t2re_s4  <= NMW'({t2rh_s3, {DW{1'b0}}}) + NMW'(t2rl_s3);
			t2im_s4  <= NMW'({t2ih_s3, {DW{1'b0}}}) + NMW'(t2il_s3);
			t1re_s4  <= t1re_s3;
			t1im_s4  <= t1im_s3;
			n1re_s4  <= n1re_s3;
			n2re_s4  <= n2re_s3;
			n1im_s4  <= n1im_s3;
			n2im_s4  <= n2im_s3;
			zero_s4  <= zero_s3;
			last_s4  <= last_s3;
		end
		if (r_s5 && v_s4) begin
			den_s5  <= DENW'({denhi_s4, {PW{1'b0}}}) + DENW'(denlo_s4);
			nre_s5  <= nm_sel(t1re5, t2re_s4, n1re_s4, n2re_s4);
			nim_s5  <= nm_sel(t1im5, t2im_s4, n1im_s4, n2im_s4);
			zero_s5 <= zero_s4;
			last_s5 <= last_s4;
		end
		if (r_s6 && v_s5) begin
			// Round to nearest: (nm * 2^(FB+1) + den) / (2 * den).
			nre_s6    <= RW'({nre_s5.nm, {(FB + 1){1'b0}}}) + RW'(den_s5);
			nim_s6    <= RW'({nim_s5.nm, {(FB + 1){1'b0}}}) + RW'(den_s5);
			dd_s6     <= RW'({den_s5, 1'b0});
			neg_re_s6 <= nre_s5.neg;
			neg_im_s6 <= nim_s5.neg;
			zero_s6   <= zero_s5;
			last_s6   <= last_s5;
		end
		if (r_s7 && v_s6) begin
			dv_start_s7.d.rem_re <= nre_s6;
			dv_start_s7.d.rem_im <= nim_s6;
			dv_start_s7.d.dsh    <= dd_s6 << (DW - 1);
			dv_start_s7.d.q_re   <= '0;
			dv_start_s7.d.q_im   <= '0;
			dv_start_s7.s.neg_re <= neg_re_s6;
			dv_start_s7.s.neg_im <= neg_im_s6;
			dv_start_s7.s.ovf_re <= nre_s6 >= dtop;
			dv_start_s7.s.ovf_im <= nim_s6 >= dtop;
			dv_start_s7.s.zero   <= zero_s6;
			dv_start_s7.s.last   <= last_s6;
		end
		if (r_o && dv_v[DV_STAGES]) begin
			re_o_q   <= dvo.s.zero ? '0 : (dvo.s.neg_re ? DW'(-val_re) : val_re);
			im_o_q   <= dvo.s.zero ? '0 : (dvo.s.neg_im ? DW'(-val_im) : val_im);
			zero_o_q <= dvo.s.zero;
			sat_o_q  <= !dvo.s.zero && (sat_re || sat_im);
			last_o_q <= dvo.s.last;
		end
	end

	assign dout.valid          = v_o_q;
	assign dout.out_re         = re_o_q;
	assign dout.out_im         = im_o_q;
	assign dout.zero_magnitude = zero_o_q;
	assign dout.saturated      = sat_o_q;
	assign dout.last_out       = last_o_q;

	// Input is refused only when every stage is full and the output is stalled.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!din.ready |-> (dout.valid && !dout.ready))
		else $error("input stalled while the pipeline had room");

	// The square root of a 48-bit value fits the data width.
	a_root_width: assert property (@(posedge clk) disable iff (!arst_n)
		sq_v[SQ_STAGES] |-> (sq_d[SQ_STAGES].d.res[SQW-1:DW] == '0))
		else $error("square root result exceeds data width");

	a_zero_out: assert property (@(posedge clk) disable iff (!arst_n)
		(dout.valid && dout.zero_magnitude) |->
		(dout.out_re == '0 && dout.out_im == '0 && !dout.saturated))
		else $error("zero magnitude result not cleared");

	// A clipped transaction carries at least one part at a range bound.
	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(dout.valid && dout.saturated) |->
		(dout.out_re == POS_LIMIT || dout.out_re == NEG_LIMIT ||
		 dout.out_im == POS_LIMIT || dout.out_im == NEG_LIMIT))
		else $error("saturated flag without a bound value");
endmodule

// File: rtl/csg_sqrt_cell.sv
// One cell of the integer square root chain: settles one result bit per
// transaction and hands the partial root to the next cell. Depends on csg_pkg.
`timescale 1ns / 1ps
module csg_sqrt_cell import csg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  sq_cell_t in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output sq_cell_t out_data
);
	logic           valid_q;
	sq_cell_t       data_q;
	sq_cell_t       nxt;
	logic [SQW-1:0] trial;
	logic           take;

	assign in_ready = !valid_q || out_ready;

	always_comb begin
		trial    = in_data.d.res + in_data.d.bw;
		take     = in_data.d.v >= trial;
		nxt      = in_data;
		nxt.d.v  = take ? in_data.d.v - trial : in_data.d.v;
		nxt.d.res = take ? (in_data.d.res >> 1) + in_data.d.bw : in_data.d.res >> 1;
		nxt.d.bw = in_data.d.bw >> 2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;
endmodule

// File: rtl/csg_div_cell.sv
// One cell of the restoring divider chain: one quotient bit for each of the
// real and imaginary lanes, with the shared divisor shifted down one place.
// Depends on csg_pkg.
`timescale 1ns / 1ps
module csg_div_cell import csg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dv_cell_t in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output dv_cell_t out_data
);
	logic     valid_q;
	dv_cell_t data_q;
	dv_cell_t nxt;
	logic     take_re;
	logic     take_im;

	assign in_ready = !valid_q || out_ready;

	always_comb begin
		take_re      = in_data.d.rem_re >= in_data.d.dsh;
		take_im      = in_data.d.rem_im >= in_data.d.dsh;
		nxt          = in_data;
		nxt.d.rem_re = take_re ? in_data.d.rem_re - in_data.d.dsh : in_data.d.rem_re;
		nxt.d.rem_im = take_im ? in_data.d.rem_im - in_data.d.dsh : in_data.d.rem_im;
		nxt.d.q_re   = {in_data.d.q_re[DW-2:0], take_re};
		nxt.d.q_im   = {in_data.d.q_im[DW-2:0], take_im};
		nxt.d.dsh    = in_data.d.dsh >> 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;
endmodule
